[rtl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg: shared types for the json string unescaper
// Payload structs, phase and status codes, the command that passes from the
// parser to the byte emitter, and the utf-8 encoding helpers.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CP_W      = 21;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] BS_CODE = 8'h08;
  localparam logic [7:0] FF_CODE = 8'h0c;
  localparam logic [7:0] LF_CODE = 8'h0a;
  localparam logic [7:0] CR_CODE = 8'h0d;
  localparam logic [7:0] HT_CODE = 8'h09;

  localparam logic [5:0] HIGH_SUR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SUR_TAG  = 6'b110111;
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

  typedef enum logic [3:0] {
    PH_AWAIT    = 4'd0,
    PH_TEXT     = 4'd1,
    PH_ESC      = 4'd2,
    PH_HEX      = 4'd3,
    PH_HELD     = 4'd4,
    PH_HELD_ESC = 4'd5,
    PH_LOW_HEX  = 4'd6,
    PH_DONE     = 4'd7,
    PH_FAILED   = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_CLOSE = 2'd1,
    ST_BAD   = 2'd2
  } st_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
  } out_t;

  typedef struct packed {
    logic            a_valid;
    logic [CP_W-1:0] a_cp;
    logic            b_valid;
    logic            b_raw;
    logic [CP_W-1:0] b_val;
    logic            st_valid;
    st_e             st;
  } cmd_t;

  typedef struct packed {
    logic            emit;
    logic            raw;
    logic [CP_W-1:0] val;
    logic            bad;
    logic            close;
    logic            hold;
    logic            clr;
    phase_e          nxt;
  } fr_step_t;

  function automatic logic [2:0] utf8_len(logic [CP_W-1:0] cp);
    logic [2:0] n;
    if (cp <= 21'h7f) begin
      n = 3'd1;
    end else if (cp <= 21'h7ff) begin
      n = 3'd2;
    end else if (cp <= 21'hffff) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(logic [CP_W-1:0] cp, logic [1:0] idx);
    logic [7:0] r;
    r = 8'h00;
    unique case (utf8_len(cp))
      3'd1: r = cp[7:0];
      3'd2: begin
        unique case (idx)
          2'd0:    r = {3'b110, cp[10:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      3'd3: begin
        unique case (idx)
          2'd0:    r = {4'b1110, cp[15:12]};
          2'd1:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (idx)
          2'd0: r = {5'b11110, cp[20:18]};
          2'd1: r = {2'b10, cp[17:12]};
          2'd2: r = {2'b10, cp[11:6]};
          2'd3: r = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/jsu_front.sv]
// ----------------------------------------------------------------------------
// jsu_front: string parser
// Walks the escape and surrogate phases one byte per cycle while full is low
// and turns each byte into a command of up to two code points and a status.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  logic in_fire_i,
  output cmd_t cmd_o,
  output logic cmd_valid_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] held_q, held_d;

  logic [7:0]  b;
  logic        eob;
  logic        hex_ok;
  logic [3:0]  hex_nib;
  logic [15:0] acc_n;
  fr_step_t    tx_s, es_s, hx_s, sel;
  cmd_t        cmd;

  assign b     = in_data_i.in_byte;
  assign eob   = in_data_i.end_of_buffer;
  assign acc_n = {acc_q[11:0], hex_nib};

  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_nib = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_nib = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_nib = 4'(b - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // plain text byte
  always_comb begin
    tx_s       = '0;
    tx_s.nxt   = PH_TEXT;
    tx_s.val   = {13'd0, b};
    tx_s.raw   = 1'b1;
    if (b == CH_QUOTE) begin
      tx_s.close = 1'b1;
      tx_s.nxt   = PH_DONE;
    end else if (b == CH_BSLASH) begin
      tx_s.nxt = PH_ESC;
    end else begin
      tx_s.emit = 1'b1;
    end
  end

  // escape letter
  always_comb begin
    es_s      = '0;
    es_s.nxt  = PH_TEXT;
    es_s.raw  = 1'b1;
    es_s.emit = 1'b1;
    es_s.val  = {13'd0, b};
    unique case (b)
      CH_QUOTE, CH_BSLASH, CH_SLASH: ;
      CH_B: es_s.val = {13'd0, BS_CODE};
      CH_F: es_s.val = {13'd0, FF_CODE};
      CH_N: es_s.val = {13'd0, LF_CODE};
      CH_R: es_s.val = {13'd0, CR_CODE};
      CH_T: es_s.val = {13'd0, HT_CODE};
      CH_U: begin
        es_s.emit = 1'b0;
        es_s.clr  = 1'b1;
        es_s.nxt  = PH_HEX;
      end
      default: begin
        es_s.emit = 1'b0;
        es_s.bad  = 1'b1;
        es_s.nxt  = PH_FAILED;
      end
    endcase
  end

  // hex digit that extends, completes or breaks a code unit
  always_comb begin
    hx_s     = '0;
    hx_s.nxt = PH_HEX;
    hx_s.val = {5'd0, acc_n};
    if (!hex_ok) begin
      hx_s.bad = 1'b1;
      hx_s.nxt = PH_FAILED;
    end else if (cnt_q == 2'd3) begin
      if (acc_n[15:10] == HIGH_SUR_TAG) begin
        hx_s.hold = 1'b1;
        hx_s.nxt  = PH_HELD;
      end else begin
        hx_s.emit = 1'b1;
        hx_s.nxt  = PH_TEXT;
      end
    end
  end

  always_comb begin
    sel      = '0;
    sel.nxt  = phase_q;
    cmd      = '0;
    cmd.st   = ST_DATA;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    held_d   = held_q;
    phase_d  = phase_q;

    unique case (phase_q)
      PH_AWAIT: begin
        if (b == CH_QUOTE) begin
          sel.nxt = PH_TEXT;
        end else begin
          sel.bad = 1'b1;
          sel.nxt = PH_FAILED;
        end
      end
      PH_TEXT: sel = tx_s;
      PH_ESC:  sel = es_s;
      PH_HEX: begin
        acc_d = acc_n;
        cnt_d = cnt_q + 2'd1;
        sel   = hx_s;
      end
      PH_HELD: begin
        if (b == CH_BSLASH) begin
          sel.nxt = PH_HELD_ESC;
        end else begin
          cmd.a_valid = 1'b1;
          cmd.a_cp    = {5'd0, held_q};
          held_d      = '0;
          sel         = tx_s;
        end
      end
      PH_HELD_ESC: begin
        if (b == CH_U) begin
          sel.clr = 1'b1;
          sel.nxt = PH_LOW_HEX;
        end else begin
          cmd.a_valid = 1'b1;
          cmd.a_cp    = {5'd0, held_q};
          held_d      = '0;
          sel         = es_s;
        end
      end
      PH_LOW_HEX: begin
        acc_d = acc_n;
        cnt_d = cnt_q + 2'd1;
        if (!hex_ok || cnt_q == 2'd3) begin
          cmd.a_valid = 1'b1;
          held_d      = '0;
          if (hex_ok && acc_n[15:10] == LOW_SUR_TAG) begin
            cmd.a_cp = SUPP_BASE + {1'b0, held_q[9:0], acc_n[9:0]};
            sel.nxt  = PH_TEXT;
          end else begin
            cmd.a_cp = {5'd0, held_q};
            sel      = hx_s;
          end
        end
      end
      default: ;
    endcase

    cmd.b_valid = sel.emit;
    cmd.b_raw   = sel.raw;
    cmd.b_val   = sel.val;
    phase_d     = sel.nxt;
    if (sel.clr) begin
      acc_d = '0;
      cnt_d = '0;
    end
    if (sel.hold) begin
      held_d = acc_n;
    end
    if (sel.close) begin
      cmd.st_valid = 1'b1;
      cmd.st       = ST_CLOSE;
    end
    if (sel.bad) begin
      cmd.st_valid = 1'b1;
      cmd.st       = ST_BAD;
      held_d       = '0;
    end

    if (eob) begin
      if (phase_d < PH_DONE) begin
        cmd.st_valid = 1'b1;
        cmd.st       = ST_BAD;
      end
      phase_d = PH_AWAIT;
      acc_d   = '0;
      cnt_d   = '0;
      held_d  = '0;
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = in_fire_i && (cmd.a_valid || cmd.b_valid || cmd.st_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_AWAIT;
      acc_q   <= '0;
      cnt_q   <= '0;
      held_q  <= '0;
    end else if (in_fire_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      held_q  <= held_d;
    end
  end

endmodule

[rtl/jsu_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// jsu_cmd_fifo: command queue
// Small first-in first-out buffer between the parser and the byte emitter.
// ----------------------------------------------------------------------------
module jsu_cmd_fifo import jsu_pkg::*; #(
  parameter int unsigned Depth = CMD_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  cmd_t wr_data_i,
  output logic full_o,
  input  logic rd_en_i,
  output cmd_t rd_data_o,
  output logic rd_valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_en_i && rd_valid_o;
  assign full_o     = cnt_q == FullCnt;
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/jsu_back.sv]
// ----------------------------------------------------------------------------
// jsu_back: byte emitter
// Expands one command into its utf-8 bytes and status result, one result per
// cycle unless the result port stalls, into the output register.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_valid_i,
  output logic cmd_pop_o,
  output out_t out_o,
  output logic empty,
  input  logic pop
);

  cmd_t       cur_q;
  logic       cur_valid_q;
  logic [3:0] k_q;
  out_t       out_q;
  logic       out_valid_q;

  logic [3:0] na, nb, nab, total;
  logic [1:0] kb;
  logic       emit_ok, fire, is_last, load;
  out_t       res;

  assign na    = cur_q.a_valid ? {1'b0, utf8_len(cur_q.a_cp)} : 4'd0;
  assign nb    = !cur_q.b_valid ? 4'd0 :
                 cur_q.b_raw ? 4'd1 : {1'b0, utf8_len(cur_q.b_val)};
  assign nab   = na + nb;
  assign total = nab + {3'd0, cur_q.st_valid};
  assign kb    = k_q[1:0] - na[1:0];

  assign emit_ok = !out_valid_q || pop;
  assign fire    = cur_valid_q && emit_ok;
  assign is_last = k_q == total - 4'd1;
  assign load    = !cur_valid_q || (fire && is_last);
  assign cmd_pop_o = load && cmd_valid_i;

  always_comb begin
    res      = '0;
    res.last = is_last;
    if (k_q < na) begin
      res.out_byte = utf8_byte(cur_q.a_cp, k_q[1:0]);
      res.status   = ST_DATA;
    end else if (k_q < nab) begin
      res.out_byte = cur_q.b_raw ? cur_q.b_val[7:0] : utf8_byte(cur_q.b_val, kb);
      res.status   = ST_DATA;
    end else begin
      res.out_byte = 8'h00;
      res.status   = cur_q.st;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= cmd_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_q <= cmd_valid_i;
        k_q         <= '0;
      end else if (fire) begin
        k_q <= k_q + 4'd1;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o = out_q;
  assign empty = !out_valid_q;

endmodule

[rtl/json_string_unescape_utf8_top.sv]
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top: json string unescaper with utf-8 output
// Takes one byte of a quoted json string per transfer and gives the decoded
// utf-8 bytes and a closing or error status.
//
// Input side: a transfer happens when push is high and full is low. Each byte
// carries an end_of_buffer flag; after that byte the block waits for a new
// opening quote.
// Result side: while empty is low the oldest result sits on out_data_o; a
// transfer happens when pop is high and empty is low. The last result caused
// by one input byte has last set. A byte may cause no result or up to seven.
// The first result of a byte passes the command queue, the emitter's command
// register and the output register. The parser takes one byte per cycle while
// full is low; the emitter gives one result per cycle unless the result port
// stalls; the queue absorbs the bursts of results that one byte can cause.
// Reset clears the parser phase, the queue and the output valid flag.
// When the receiver stalls, the result holds; the queue then fills and full
// rises until results drain.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top import jsu_pkg::*; #(
  parameter int unsigned CmdDepth = CMD_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  logic push,
  output logic full,
  output out_t out_data_o,
  output logic empty,
  input  logic pop
);

  cmd_t front_cmd, fifo_cmd;
  logic front_cmd_valid, fifo_valid, back_pop, in_fire;

  assign in_fire = push && !full;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .in_fire_i   (in_fire),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_cmd_valid)
  );

  jsu_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (front_cmd_valid),
    .wr_data_i  (front_cmd),
    .full_o     (full),
    .rd_en_i    (back_pop),
    .rd_data_o  (fifo_cmd),
    .rd_valid_o (fifo_valid)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (fifo_cmd),
    .cmd_valid_i (fifo_valid),
    .cmd_pop_o   (back_pop),
    .out_o       (out_data_o),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

[rtl/jsu_checker.sv]
// ----------------------------------------------------------------------------
// jsu_checker: port checks for the json string unescaper
// Watches the result port for stall hold and consistent status results.
// ----------------------------------------------------------------------------
module jsu_checker import jsu_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input out_t out_data_o,
  input logic empty,
  input logic pop
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("result changed while stalled");

  a_status_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.status != ST_DATA) |-> (out_data_o.out_byte == 8'h00))
    else $error("status result with nonzero byte");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_data_o.status == ST_DATA || out_data_o.status == ST_CLOSE ||
                out_data_o.status == ST_BAD))
    else $error("undefined status code");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.status != ST_DATA) |-> out_data_o.last)
    else $error("status result not marked last");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_data_o (out_data_o),
  .empty      (empty),
  .pop        (pop)
);
